@@ sv/chse_pkg.sv @@
// Shared widths, status codes, payload structs and the round/saturate helper
// for the cubic Hermite segment evaluator. No dependencies.
package chse_pkg;

  localparam int VAL_W      = 32;              // Q16.16 value width
  localparam int TIME_W     = 32;              // time tick width
  localparam int STAT_W     = 3;
  localparam int FB         = 30;              // binary point of normalized time
  localparam int Q_W        = FB + 1;          // f in [0, 2^30]
  localparam int NUM_W      = 63;              // divider dividend
  localparam int DEN_W      = 32;              // divider divisor
  localparam int DIV_STAGES = NUM_W;           // one quotient bit per stage
  localparam int WIDE_W     = 64;              // signed r1, r2, s0, s1, h*T
  localparam int WGT_W      = 35;              // basis weights, signed Q.30
  localparam int PW         = WGT_W + VAL_W;   // weight x value
  localparam int LO_W       = 33 + WGT_W;      // low partial product
  localparam int HI_W       = 32 + WGT_W;      // high partial product
  localparam int ACC_W      = 100;             // exact term sums
  localparam int NPROD      = 6;               // wide products

  localparam logic signed [WGT_W-1:0] W_ONE  = WGT_W'(1) << FB;
  localparam logic signed [ACC_W-1:0] RND_LO = ACC_W'(1) << (FB - 1);
  localparam logic signed [ACC_W-1:0] RND_HI = ACC_W'(1) << (2 * FB - 1);
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_DUR  = 3'd1,
    ST_CLAMP_LO = 3'd2,
    ST_CLAMP_HI = 3'd3,
    ST_SAT      = 3'd4
  } status_t;

  // payload riding beside the first divider bank
  typedef struct packed {
    logic              bad;
    status_t           st;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] ts;
    logic [VAL_W-1:0]  p0;
    logic [VAL_W-1:0]  p1;
    logic [VAL_W-1:0]  v0;
    logic [VAL_W-1:0]  v1;
    logic              dneg;
    logic              v0neg;
    logic              v1neg;
  } side_a_t;

  // payload riding beside the second divider, then into the polynomial stages
  typedef struct packed {
    logic              bad;
    status_t           st;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] ts;
    logic [VAL_W-1:0]  p0;
    logic [VAL_W-1:0]  p1;
    logic [VAL_W-1:0]  v0;
    logic [VAL_W-1:0]  v1;
    logic [Q_W-1:0]    fq;
    logic [WIDE_W-1:0] r1;
    logic [WIDE_W-1:0] s0;
    logic [WIDE_W-1:0] s1;
    logic              dneg;
  } side_b_t;

  typedef struct packed {
    logic             sat;
    logic [VAL_W-1:0] val;
  } sat_res_t;

  // x already carries its rounding constant; shift by 30 or 60, clip to VAL_W
  function automatic sat_res_t rnd_sat(input logic signed [ACC_W-1:0] x,
                                       input logic wide);
    logic signed [ACC_W-1:0] sh;
    sat_res_t r;
    sh = wide ? (x >>> (2 * FB)) : (x >>> FB);
    r.sat = (sh != ACC_W'($signed(sh[VAL_W-1:0])));
    if (r.sat) begin
      r.val = sh[ACC_W-1] ? VAL_MIN : VAL_MAX;
    end else begin
      r.val = sh[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/chse_if.sv @@
// Valid/ready channel interfaces for segment beats and result beats.
// Depends on chse_pkg.
interface chse_in_if import chse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] segment_start_time;
  logic [TIME_W-1:0] segment_end_time;
  logic [TIME_W-1:0] sample_time;
  logic [VAL_W-1:0]  start_pos;
  logic [VAL_W-1:0]  start_vel;
  logic [VAL_W-1:0]  end_pos;
  logic [VAL_W-1:0]  end_vel;

  modport source (output valid, segment_start_time, segment_end_time, sample_time,
                  start_pos, start_vel, end_pos, end_vel, input ready);
  modport sink   (input valid, segment_start_time, segment_end_time, sample_time,
                  start_pos, start_vel, end_pos, end_vel, output ready);
endinterface

interface chse_out_if import chse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  out_pos;
  logic [VAL_W-1:0]  out_vel;
  logic [VAL_W-1:0]  out_acc;
  logic [TIME_W-1:0] out_time;
  logic [STAT_W-1:0] status;

  modport source (output valid, out_pos, out_vel, out_acc, out_time, status,
                  input ready);
  modport sink   (input valid, out_pos, out_vel, out_acc, out_time, status,
                  output ready);
endinterface

@@ sv/chse_div.sv @@
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// Depends on chse_pkg. Stages advance only while en is high.
module chse_div import chse_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot
);

  logic [DEN_W-1:0] rem_r  [DIV_STAGES];
  logic [NUM_W-1:0] num_r  [DIV_STAGES];
  logic [NUM_W-1:0] quot_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r  [DIV_STAGES];

  logic [DEN_W-1:0] rem_i  [DIV_STAGES];
  logic [NUM_W-1:0] num_i  [DIV_STAGES];
  logic [NUM_W-1:0] quot_i [DIV_STAGES];
  logic [DEN_W-1:0] den_i  [DIV_STAGES];

  logic [DEN_W-1:0] rem_nxt  [DIV_STAGES];
  logic [NUM_W-1:0] num_nxt  [DIV_STAGES];
  logic [NUM_W-1:0] quot_nxt [DIV_STAGES];
  logic [DEN_W-1:0] den_nxt  [DIV_STAGES];

  logic [DEN_W:0] trial;

  always_comb begin
    rem_i[0]  = '0;
    num_i[0]  = num;
    quot_i[0] = '0;
    den_i[0]  = den;
    for (int k = 1; k < DIV_STAGES; k++) begin
      rem_i[k]  = rem_r[k-1];
      num_i[k]  = num_r[k-1];
      quot_i[k] = quot_r[k-1];
      den_i[k]  = den_r[k-1];
    end
    trial = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial = {rem_i[k], num_i[k][NUM_W-1]};
      if (trial >= {1'b0, den_i[k]}) begin
        rem_nxt[k]  = DEN_W'(trial - {1'b0, den_i[k]});
        quot_nxt[k] = {quot_i[k][NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = trial[DEN_W-1:0];
        quot_nxt[k] = {quot_i[k][NUM_W-2:0], 1'b0};
      end
      num_nxt[k] = {num_i[k][NUM_W-2:0], 1'b0};
      den_nxt[k] = den_i[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        num_r[k]  <= num_nxt[k];
        quot_r[k] <= quot_nxt[k];
        den_r[k]  <= den_nxt[k];
      end
    end
  end

  assign quot = quot_r[DIV_STAGES-1];

endmodule

@@ sv/chse_poly.sv @@
// Hermite basis weights, term products, sums and round/saturate, nine stages
// ending in the result register. Depends on chse_pkg.
module chse_poly import chse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  side_b_t                  side,
  input  logic signed [WIDE_W-1:0] r2,
  output logic                     out_valid,
  output logic [VAL_W-1:0]         out_pos,
  output logic [VAL_W-1:0]         out_vel,
  output logic [VAL_W-1:0]         out_acc,
  output logic [TIME_W-1:0]        out_time,
  output status_t                  out_status
);

  typedef struct packed {
    logic              bad;
    status_t           st;
    logic [TIME_W-1:0] ts;
  } tag_t;

  // valid bits per stage
  logic [8:0] v_r;

  // stage 1/2: f^2, f^3
  side_b_t                  s1_side_r, s2_side_r, s3_side_r, s4_side_r;
  logic signed [WIDE_W-1:0] s1_r2_r, s2_r2_r, s3_r2_r, s4_r2_r;
  logic [Q_W-1:0]           s1_fq_r, s1_f2_r, s2_fq_r, s2_f2_r, s2_f3_r;
  logic [2*Q_W-1:0]         sq, cube;

  // stage 3: weights
  logic signed [WGT_W-1:0] wf, wf2, wf3;
  logic signed [WGT_W-1:0] h00_r, h01_r, h10_r, h11_r, g_r, k0_r, k1_r, c1_r, c2_r, c3_r;

  // stage 4
  logic signed [2*WGT_W-1:0] p10, p11;
  logic signed [WGT_W-1:0]   dur_w;
  logic signed [WIDE_W-1:0]  a10_r, a11_r;
  logic signed [PW-1:0]      m00_r, m01_r, mk0_r, mk1_r;
  logic signed [WGT_W-1:0]   s4_g_r, s4_c1_r, s4_c2_r, s4_c3_r;

  // stage 5: partial products
  logic signed [WIDE_W-1:0] xw [NPROD];
  logic signed [WGT_W-1:0]  ww [NPROD];
  logic signed [LO_W-1:0]   lo_r [NPROD];
  logic signed [HI_W-1:0]   hi_r [NPROD];
  logic signed [PW-1:0]     s5_m00_r, s5_m01_r, s5_mk0_r, s5_mk1_r;
  tag_t                     s5_tag_r, s6_tag_r, s7_tag_r, s8_tag_r;

  // stage 6..8
  logic signed [ACC_W-1:0] prod_r [NPROD];
  logic signed [ACC_W-1:0] s6_m00_r, s6_m01_r, s6_mk0_r, s6_mk1_r;
  logic signed [ACC_W-1:0] pos_a_r, pos_b_r, vel_a_r, vel_b_r, acc_a_r, acc_b_r;
  logic signed [ACC_W-1:0] pos_s_r, vel_s_r, acc_s_r;

  // stage 9: result register
  sat_res_t rp, rv, ra;
  logic [VAL_W-1:0]  pos_r, vel_r, acc_r;
  logic [TIME_W-1:0] time_r;
  status_t           stat_r;

  assign sq    = side.fq * side.fq;
  assign cube  = s1_f2_r * s1_fq_r;
  assign wf    = $signed(WGT_W'(s2_fq_r));
  assign wf2   = $signed(WGT_W'(s2_f2_r));
  assign wf3   = $signed(WGT_W'(s2_f3_r));
  assign dur_w = $signed(WGT_W'(s3_side_r.dur));
  assign p10   = h10_r * dur_w;
  assign p11   = h11_r * dur_w;

  always_comb begin
    xw[0] = a10_r;
    xw[1] = a11_r;
    xw[2] = $signed(s4_side_r.r1);
    xw[3] = s4_r2_r;
    xw[4] = $signed(s4_side_r.s0);
    xw[5] = $signed(s4_side_r.s1);
    ww[0] = WGT_W'($signed(s4_side_r.v0));
    ww[1] = WGT_W'($signed(s4_side_r.v1));
    ww[2] = s4_g_r;
    ww[3] = s4_c1_r;
    ww[4] = s4_c2_r;
    ww[5] = s4_c3_r;
  end

  assign rp = rnd_sat(pos_s_r, 1'b0);
  assign rv = rnd_sat(vel_s_r, 1'b1);
  assign ra = rnd_sat(acc_s_r, 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      s1_side_r <= side;
      s1_r2_r   <= r2;
      s1_fq_r   <= side.fq;
      s1_f2_r   <= sq[FB +: Q_W];
      // stage 2
      s2_side_r <= s1_side_r;
      s2_r2_r   <= s1_r2_r;
      s2_fq_r   <= s1_fq_r;
      s2_f2_r   <= s1_f2_r;
      s2_f3_r   <= cube[FB +: Q_W];
      // stage 3
      s3_side_r <= s2_side_r;
      s3_r2_r   <= s2_r2_r;
      h00_r <= 2 * wf3 - 3 * wf2 + W_ONE;
      h01_r <= 3 * wf2 - 2 * wf3;
      h10_r <= wf3 - 2 * wf2 + wf;
      h11_r <= wf3 - wf2;
      g_r   <= 6 * wf2 - 6 * wf;
      k0_r  <= 3 * wf2 - 4 * wf + W_ONE;
      k1_r  <= 3 * wf2 - 2 * wf;
      c1_r  <= 12 * wf - 6 * W_ONE;
      c2_r  <= 6 * wf - 4 * W_ONE;
      c3_r  <= 6 * wf - 2 * W_ONE;
      // stage 4
      s4_side_r <= s3_side_r;
      s4_r2_r   <= s3_r2_r;
      a10_r   <= p10[WIDE_W-1:0];
      a11_r   <= p11[WIDE_W-1:0];
      m00_r   <= h00_r * $signed(s3_side_r.p0);
      m01_r   <= h01_r * $signed(s3_side_r.p1);
      mk0_r   <= k0_r * $signed(s3_side_r.v0);
      mk1_r   <= k1_r * $signed(s3_side_r.v1);
      s4_g_r  <= g_r;
      s4_c1_r <= c1_r;
      s4_c2_r <= c2_r;
      s4_c3_r <= c3_r;
      // stage 5: split each wide operand at bit 32
      for (int i = 0; i < NPROD; i++) begin
        lo_r[i] <= $signed({1'b0, xw[i][31:0]}) * ww[i];
        hi_r[i] <= $signed(xw[i][WIDE_W-1:32]) * ww[i];
      end
      s5_m00_r <= m00_r;
      s5_m01_r <= m01_r;
      s5_mk0_r <= mk0_r;
      s5_mk1_r <= mk1_r;
      s5_tag_r <= '{bad: s4_side_r.bad, st: s4_side_r.st, ts: s4_side_r.ts};
      // stage 6
      for (int i = 0; i < NPROD; i++) begin
        prod_r[i] <= (ACC_W'(hi_r[i]) <<< 32) + ACC_W'(lo_r[i]);
      end
      s6_m00_r <= ACC_W'(s5_m00_r);
      s6_m01_r <= ACC_W'(s5_m01_r);
      s6_mk0_r <= ACC_W'(s5_mk0_r) <<< FB;
      s6_mk1_r <= ACC_W'(s5_mk1_r) <<< FB;
      s6_tag_r <= s5_tag_r;
      // stage 7
      pos_a_r  <= s6_m00_r + s6_m01_r;
      pos_b_r  <= prod_r[0] + prod_r[1];
      vel_a_r  <= prod_r[2] + s6_mk0_r;
      vel_b_r  <= s6_mk1_r;
      acc_a_r  <= prod_r[3] + prod_r[4];
      acc_b_r  <= prod_r[5];
      s7_tag_r <= s6_tag_r;
      // stage 8
      pos_s_r  <= pos_a_r + pos_b_r + RND_LO;
      vel_s_r  <= vel_a_r + vel_b_r + RND_HI;
      acc_s_r  <= acc_a_r + acc_b_r + RND_HI;
      s8_tag_r <= s7_tag_r;
      // stage 9
      time_r <= s8_tag_r.ts;
      if (s8_tag_r.bad) begin
        pos_r  <= '0;
        vel_r  <= '0;
        acc_r  <= '0;
        stat_r <= ST_BAD_DUR;
      end else begin
        pos_r  <= rp.val;
        vel_r  <= rv.val;
        acc_r  <= ra.val;
        stat_r <= (rp.sat || rv.sat || ra.sat) ? ST_SAT : s8_tag_r.st;
      end
    end
  end

  assign out_valid  = v_r[8];
  assign out_pos    = pos_r;
  assign out_vel    = vel_r;
  assign out_acc    = acc_r;
  assign out_time   = time_r;
  assign out_status = stat_r;

endmodule

@@ sv/cubic_hermite_segment_eval_unit.sv @@
// Cubic Hermite segment evaluator. One beat per clock in and out while the
// result side takes beats. The path runs through two banks of 63-stage
// bit-per-stage dividers (normalized time and slopes, then the second
// division of the position slope by the duration) followed by nine stages of
// basis weights, products, sums and round/saturate. A held result stalls the
// whole pipeline. Depends on chse_pkg, chse_if, chse_div and chse_poly.
module cubic_hermite_segment_eval_unit import chse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  chse_in_if.sink           in_ch,
  chse_out_if.source        out_ch
);

  logic en;
  logic poly_valid;

  // entry
  logic [TIME_W-1:0] dur, dt;
  logic              clamp_lo, clamp_hi;
  logic [VAL_W:0]    d, dmag;
  logic [VAL_W-1:0]  v0mag, v1mag;
  side_a_t           sa;
  logic [NUM_W-1:0]  num_f, num_d, num_v0, num_v1;

  // divider outputs
  logic [NUM_W-1:0] q_f, q_d, q_v0, q_v1, q_r2;

  side_a_t da_r [DIV_STAGES];
  logic    va_r [DIV_STAGES];
  side_b_t db_r [DIV_STAGES];
  logic    vb_r [DIV_STAGES];

  side_a_t                  sa_o;
  side_b_t                  sb;
  logic signed [WIDE_W-1:0] r2;

  status_t stat;

  assign en = !poly_valid || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    dur      = in_ch.segment_end_time - in_ch.segment_start_time;
    clamp_lo = in_ch.sample_time < in_ch.segment_start_time;
    clamp_hi = in_ch.sample_time > in_ch.segment_end_time;
    if (clamp_lo) begin
      dt = '0;
    end else if (clamp_hi) begin
      dt = dur;
    end else begin
      dt = in_ch.sample_time - in_ch.segment_start_time;
    end
    d     = {in_ch.start_pos[VAL_W-1], in_ch.start_pos}
          - {in_ch.end_pos[VAL_W-1], in_ch.end_pos};
    dmag  = d[VAL_W] ? (VAL_W+1)'(-d) : d;
    v0mag = in_ch.start_vel[VAL_W-1] ? VAL_W'(-in_ch.start_vel) : in_ch.start_vel;
    v1mag = in_ch.end_vel[VAL_W-1] ? VAL_W'(-in_ch.end_vel) : in_ch.end_vel;

    // |d| needs all 33 bits
    num_f  = NUM_W'({dt, {FB{1'b0}}});
    num_d  = NUM_W'({dmag, {FB{1'b0}}});
    num_v0 = NUM_W'({v0mag, {FB{1'b0}}});
    num_v1 = NUM_W'({v1mag, {FB{1'b0}}});

    sa.bad   = in_ch.segment_end_time <= in_ch.segment_start_time;
    sa.st    = clamp_lo ? ST_CLAMP_LO : (clamp_hi ? ST_CLAMP_HI : ST_OK);
    sa.dur   = dur;
    sa.ts    = in_ch.sample_time;
    sa.p0    = in_ch.start_pos;
    sa.p1    = in_ch.end_pos;
    sa.v0    = in_ch.start_vel;
    sa.v1    = in_ch.end_vel;
    sa.dneg  = d[VAL_W];
    sa.v0neg = in_ch.start_vel[VAL_W-1];
    sa.v1neg = in_ch.end_vel[VAL_W-1];
  end

  chse_div u_div_f  (.clk(clk), .en(en), .num(num_f),  .den(dur), .quot(q_f));
  chse_div u_div_d  (.clk(clk), .en(en), .num(num_d),  .den(dur), .quot(q_d));
  chse_div u_div_v0 (.clk(clk), .en(en), .num(num_v0), .den(dur), .quot(q_v0));
  chse_div u_div_v1 (.clk(clk), .en(en), .num(num_v1), .den(dur), .quot(q_v1));

  // truncating signed quotients from magnitudes
  always_comb begin
    sa_o    = da_r[DIV_STAGES-1];
    sb.bad  = sa_o.bad;
    sb.st   = sa_o.st;
    sb.dur  = sa_o.dur;
    sb.ts   = sa_o.ts;
    sb.p0   = sa_o.p0;
    sb.p1   = sa_o.p1;
    sb.v0   = sa_o.v0;
    sb.v1   = sa_o.v1;
    sb.fq   = q_f[Q_W-1:0];
    sb.r1   = sa_o.dneg  ? WIDE_W'(-WIDE_W'(q_d))  : WIDE_W'(q_d);
    sb.s0   = sa_o.v0neg ? WIDE_W'(-WIDE_W'(q_v0)) : WIDE_W'(q_v0);
    sb.s1   = sa_o.v1neg ? WIDE_W'(-WIDE_W'(q_v1)) : WIDE_W'(q_v1);
    sb.dneg = sa_o.dneg;
  end

  // second division: |r2| = floor(|r1| / T), same sign as r1
  chse_div u_div_r2 (.clk(clk), .en(en), .num(q_d), .den(sa_o.dur), .quot(q_r2));

  assign r2 = db_r[DIV_STAGES-1].dneg ? $signed(WIDE_W'(-WIDE_W'(q_r2)))
                                      : $signed(WIDE_W'(q_r2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        va_r[k] <= 1'b0;
        vb_r[k] <= 1'b0;
      end
    end else if (en) begin
      va_r[0] <= in_ch.valid;
      vb_r[0] <= va_r[DIV_STAGES-1];
      for (int k = 1; k < DIV_STAGES; k++) begin
        va_r[k] <= va_r[k-1];
        vb_r[k] <= vb_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da_r[0] <= sa;
      db_r[0] <= sb;
      for (int k = 1; k < DIV_STAGES; k++) begin
        da_r[k] <= da_r[k-1];
        db_r[k] <= db_r[k-1];
      end
    end
  end

  chse_poly u_poly (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (vb_r[DIV_STAGES-1]),
    .side       (db_r[DIV_STAGES-1]),
    .r2         (r2),
    .out_valid  (poly_valid),
    .out_pos    (out_ch.out_pos),
    .out_vel    (out_ch.out_vel),
    .out_acc    (out_ch.out_acc),
    .out_time   (out_ch.out_time),
    .out_status (stat)
  );

  assign out_ch.valid  = poly_valid;
  assign out_ch.status = stat;

endmodule

@@ bench/tb_chse_if.sv @@
`timescale 1ns / 100ps
// Bench-side copy is not needed: the channel interfaces come from sv/chse_if.sv.
// This file holds the bench's small shared types. Depends on chse_pkg.
package tb_chse_types_pkg;
  import chse_pkg::*;

  typedef struct {
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] ts;
    logic [VAL_W-1:0]  p0;
    logic [VAL_W-1:0]  v0;
    logic [VAL_W-1:0]  p1;
    logic [VAL_W-1:0]  v1;
  } segment_t;

  typedef struct {
    logic [VAL_W-1:0]  pos;
    logic [VAL_W-1:0]  vel;
    logic [VAL_W-1:0]  acc;
    logic [TIME_W-1:0] tstamp;
    logic [STAT_W-1:0] st;
  } sample_t;
endpackage

@@ bench/tb_cubic_hermite_segment_eval_unit.sv @@
`timescale 1ns / 100ps
// Bench for the cubic Hermite segment evaluator: directed edge segments, then
// random segments, mostly with random idling on both channels, each result checked
// against an in-bench fixed-point predictor. Depends on chse_pkg, chse_if, tb_chse_types_pkg and the unit.
module tb_cubic_hermite_segment_eval_unit;
  import chse_pkg::*;
  import tb_chse_types_pkg::*;

  localparam int LATENCY = 135;

  logic clk;
  logic rst_n;
  chse_in_if  in_ch ();
  chse_out_if out_ch ();

  cubic_hermite_segment_eval_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  sample_t expected_samples[$];
  int      mismatches;
  int      results_seen;
  int      segments_sent;
  int      bad_dur_seen;
  int      clamp_seen;
  int      sat_seen;
  bit      no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // floor-shift rounding of an exact sum, then clip to VAL_W bits
  function automatic logic [VAL_W-1:0] round_clip(input logic signed [127:0] x,
                                                  input int sh, inout bit sat);
    logic signed [127:0] y;
    y = (x + (128'sd1 <<< (sh - 1))) >>> sh;
    if (y > 128'sd2147483647) begin
      sat = 1'b1;
      return VAL_MAX;
    end
    if (y < -128'sd2147483648) begin
      sat = 1'b1;
      return VAL_MIN;
    end
    return y[VAL_W-1:0];
  endfunction

  function automatic sample_t hermite_predict(input segment_t s);
    sample_t r;
    logic signed [127:0] one, T, f, f2, f3, p0, p1, v0, v1, d, r1, r2, s0, s1, a;
    logic [63:0] fu;
    status_t st;
    bit sat;
    sat = 1'b0;
    st = ST_OK;
    r.tstamp = s.ts;
    if (s.t1 <= s.t0) begin
      r.pos = '0; r.vel = '0; r.acc = '0; r.st = ST_BAD_DUR;
      return r;
    end
    one = 128'sd1 <<< FB;
    T = 128'(s.t1 - s.t0);
    if (s.ts < s.t0) begin
      fu = 0; st = ST_CLAMP_LO;
    end else if (s.ts > s.t1) begin
      fu = 64'd1 << FB; st = ST_CLAMP_HI;
    end else begin
      fu = (64'(s.ts - s.t0) << FB) / 64'(s.t1 - s.t0);
    end
    f = 128'(fu);
    f2 = (f * f) >>> FB;
    f3 = (f2 * f) >>> FB;
    p0 = 128'($signed(s.p0)); p1 = 128'($signed(s.p1));
    v0 = 128'($signed(s.v0)); v1 = 128'($signed(s.v1));
    a = (2*f3 - 3*f2 + one) * p0 + (3*f2 - 2*f3) * p1
      + (f3 - 2*f2 + f) * T * v0 + (f3 - f2) * T * v1;
    r.pos = round_clip(a, FB, sat);
    d = p0 - p1;
    r1 = (d * one) / T;   // SV signed division truncates toward zero
    a = (6*f2 - 6*f) * r1 + (3*f2 - 4*f + one) * (v0 * one) + (3*f2 - 2*f) * (v1 * one);
    r.vel = round_clip(a, 2*FB, sat);
    r2 = r1 / T;
    s0 = (v0 * one) / T;
    s1 = (v1 * one) / T;
    a = (12*f - 6*one) * r2 + (6*f - 4*one) * s0 + (6*f - 2*one) * s1;
    r.acc = round_clip(a, 2*FB, sat);
    r.st = sat ? ST_SAT : st;
    return r;
  endfunction

  // valid stays up after the beat; the next call's idle loop or the caller drops it
  task automatic send_segment(input segment_t s);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.segment_start_time <= s.t0;
    in_ch.segment_end_time <= s.t1;
    in_ch.sample_time <= s.ts;
    in_ch.start_pos <= s.p0;
    in_ch.start_vel <= s.v0;
    in_ch.end_pos <= s.p1;
    in_ch.end_vel <= s.v1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_samples = {expected_samples, hermite_predict(s)};
    segments_sent++;
    @(negedge clk);
  endtask

  // result side: ready toggles at falling edges, beats taken at rising edges
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= no_idle || ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat t=%0d", out_ch.out_time);
      end else begin
        e = expected_samples.pop_front();
        if (e.st == ST_BAD_DUR) bad_dur_seen++;
        if (e.st == ST_CLAMP_LO || e.st == ST_CLAMP_HI) clamp_seen++;
        if (e.st == ST_SAT) sat_seen++;
        if (out_ch.out_pos !== e.pos || out_ch.out_vel !== e.vel ||
            out_ch.out_acc !== e.acc || out_ch.out_time !== e.tstamp ||
            out_ch.status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp pos=%h vel=%h acc=%h t=%h st=%0d got %h %h %h %h %0d",
                     e.pos, e.vel, e.acc, e.tstamp, e.st, out_ch.out_pos,
                     out_ch.out_vel, out_ch.out_acc, out_ch.out_time, out_ch.status);
        end
      end
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    logic [31:0] dur;
    s.t0 = $urandom;
    case ($urandom_range(9))
      0: dur = 0;
      1: dur = $urandom;
      2: dur = 1;
      default: dur = $urandom_range(1000, 1);
    endcase
    s.t1 = s.t0 + dur;
    if ($urandom_range(9) == 0) s.t1 = s.t0 - $urandom_range(100);
    case ($urandom_range(9))
      0: s.ts = s.t0 - $urandom_range(50, 1);
      1: s.ts = s.t1 + $urandom_range(50, 1);
      2: s.ts = $urandom;
      default: s.ts = s.t0 + $urandom_range(dur);
    endcase
    s.p0 = rand_val(); s.p1 = rand_val(); s.v0 = rand_val(); s.v1 = rand_val();
    return s;
  endfunction

  task automatic seg(input logic [31:0] t0, t1, ts, p0, v0, p1, v1);
    segment_t s;
    s.t0 = t0; s.t1 = t1; s.ts = ts; s.p0 = p0; s.v0 = v0; s.p1 = p1; s.v1 = v1;
    send_segment(s);
  endtask

  task automatic test_directed();
    seg(100, 200, 150, 32'h00010000, 0, 32'h00050000, 0);          // plain midpoint
    seg(100, 200, 100, 32'h00010000, 32'h100, 32'h00050000, 32'hffffff00);
    seg(100, 200, 200, 32'h00010000, 32'h100, 32'h00050000, 32'h100); // at end, no clamp
    seg(100, 200, 50, 32'h00010000, 0, 32'h00050000, 0);            // clamp low
    seg(100, 200, 300, 32'h00010000, 0, 32'h00050000, 0);           // clamp high
    seg(100, 100, 100, 32'h00010000, 0, 32'h00050000, 0);           // zero duration
    seg(200, 100, 150, 32'h00010000, 0, 32'h00050000, 0);           // negative duration
    seg(0, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
        32'h80000000, 32'h80000000);                                // widest span
    seg(0, 1, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000); // saturation
    seg(0, 1, 1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    seg(32'hffffffff, 32'hffffffff, 0, 0, 0, 0, 0);
    seg(5, 8, 6, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    seg(0, 3, 32'hffffffff, 0, 32'h00008000, 0, 32'hffff8000);
    seg(10, 13, 11, 32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555);
  endtask

  task automatic test_random(input int n);
    repeat (n) send_segment(rand_segment());
  endtask

  initial begin
    rst_n = 1'b0;
    no_idle = 1'b0;
    mismatches = 0; results_seen = 0; segments_sent = 0;
    bad_dur_seen = 0; clamp_seen = 0; sat_seen = 0;
    in_ch.valid = 1'b0;
    in_ch.segment_start_time = '0; in_ch.segment_end_time = '0;
    in_ch.sample_time = '0; in_ch.start_pos = '0; in_ch.start_vel = '0;
    in_ch.end_pos = '0; in_ch.end_vel = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(900);
    no_idle = 1'b1;          // back-to-back stretch
    test_random(400);
    no_idle = 1'b0;
    test_random(536);
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d segments sent, %0d results checked", segments_sent, results_seen);
    $display("bad duration %0d, clamped %0d, saturated %0d, mismatches %0d",
             bad_dur_seen, clamp_seen, sat_seen, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
